@@ sv/bcv_pkg.sv @@
// Shared types and constants for the Bessel-corrected variance block.
package bcv_pkg;

  localparam int unsigned MAX_COUNT_DEF    = 65536;
  localparam int unsigned SAMPLE_WIDTH_DEF = 16;

  localparam int unsigned ALU_W   = 64;
  localparam int unsigned ALU_CW  = $clog2(ALU_W + 1);
  localparam int unsigned MEAN_W  = 16;
  localparam int unsigned VAR_W   = 32;
  localparam int unsigned STAT_W  = 2;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_rsp_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK,
    STAT_ONE,
    STAT_OVF
  } status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ,
    ST_ACC,
    ST_CHK,
    ST_DIV_MEAN,
    ST_MUL_SQ,
    ST_DIV_Q,
    ST_DIFF,
    ST_DIV_VAR,
    ST_OUT
  } state_e;

endpackage

@@ sv/bessel_corrected_variance.sv @@
// Each sample is accepted, squared and accumulated, and input stalls meanwhile; once
// the count is full, further samples are dropped and flag overflow. A sample marked
// last then runs four 64-step operations on the shared multiply/divide unit when the
// set holds more than one sample; a set of one sample goes straight to the output.
// Reset clears the count, the sums, the overflow flag and the output valid.
module bessel_corrected_variance #(
  parameter int unsigned MAX_COUNT    = bcv_pkg::MAX_COUNT_DEF,
  parameter int unsigned SAMPLE_WIDTH = bcv_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [SAMPLE_WIDTH-1:0]       sample_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bcv_pkg::VAR_W-1:0]     corrected_variance_o,
  output logic [bcv_pkg::MEAN_W-1:0]    mean_o,
  output logic [bcv_pkg::STAT_W-1:0]    status_o
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam int unsigned CW    = $clog2(MAX_COUNT + 1);
  localparam int unsigned SUMW  = SW + CW;
  localparam int unsigned QFULL = 2 * SW - 2 + CW;
  localparam int unsigned QW    = (QFULL > bcv_pkg::ALU_W) ? bcv_pkg::ALU_W : QFULL;
  localparam int unsigned AW    = bcv_pkg::ALU_W;
  localparam int unsigned MW    = bcv_pkg::MEAN_W;
  localparam int unsigned VW    = bcv_pkg::VAR_W;

  bcv_pkg::state_e   state_q, state_d;
  logic [SUMW-1:0]   sum_q;
  logic [QW-1:0]     sqsum_q;
  logic [CW-1:0]     cnt_q;
  logic              ovf_q;
  logic              out_valid_q;

  logic [SW-1:0]     x_q;
  logic [SW-1:0]     mag_q;
  logic              last_q;
  logic [2*SW-1:0]   sqr_q;
  logic [SUMW-2:0]   smag_q;
  logic              sneg_q;
  logic [AW-1:0]     tmp_q;
  logic [MW-1:0]     mean_q;
  logic [VW-1:0]     var_q;
  bcv_pkg::status_e  stat_q;
  logic [VW-1:0]     var_out_q;
  logic [MW-1:0]     mean_out_q;
  logic [bcv_pkg::STAT_W-1:0] stat_out_q;

  logic              in_acc;
  logic              full;
  logic              out_free;
  logic              out_load;
  logic              alu_state;
  logic [SW-1:0]     neg_x;
  logic [SUMW-1:0]   neg_sum;
  logic [CW-1:0]     nm1;
  logic [AW-1:0]     sqsum_ext;
  logic [MW-1:0]     res_lo;

  bcv_pkg::alu_req_t alu_req;
  bcv_pkg::alu_rsp_t alu_rsp;
  logic [AW-1:0]     alu_a;
  logic [AW-1:0]     alu_b;
  logic [AW-1:0]     alu_res;

  bcv_alu u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (alu_a),
    .b_i      (alu_b),
    .rsp_o    (alu_rsp),
    .result_o (alu_res)
  );

  assign in_acc    = in_valid_i && !in_stall_o;
  assign full      = (cnt_q == CW'(MAX_COUNT));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign neg_x     = ~sample_i + SW'(1);
  assign neg_sum   = ~sum_q + SUMW'(1);
  assign nm1       = cnt_q - CW'(1);
  assign sqsum_ext = AW'(sqsum_q);
  assign res_lo    = alu_res[MW-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      bcv_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (full) begin
            state_d = last_i ? bcv_pkg::ST_CHK : bcv_pkg::ST_IDLE;
          end else begin
            state_d = bcv_pkg::ST_SQ;
          end
        end
      end
      bcv_pkg::ST_SQ: state_d = bcv_pkg::ST_ACC;
      bcv_pkg::ST_ACC: state_d = last_q ? bcv_pkg::ST_CHK : bcv_pkg::ST_IDLE;
      bcv_pkg::ST_CHK: begin
        state_d = (cnt_q <= CW'(1)) ? bcv_pkg::ST_OUT : bcv_pkg::ST_DIV_MEAN;
      end
      bcv_pkg::ST_DIV_MEAN: if (alu_rsp.done) state_d = bcv_pkg::ST_MUL_SQ;
      bcv_pkg::ST_MUL_SQ: if (alu_rsp.done) state_d = bcv_pkg::ST_DIV_Q;
      bcv_pkg::ST_DIV_Q: if (alu_rsp.done) state_d = bcv_pkg::ST_DIFF;
      bcv_pkg::ST_DIFF: state_d = bcv_pkg::ST_DIV_VAR;
      bcv_pkg::ST_DIV_VAR: if (alu_rsp.done) state_d = bcv_pkg::ST_OUT;
      bcv_pkg::ST_OUT: if (out_free) state_d = bcv_pkg::ST_IDLE;
      default: state_d = bcv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o    = (state_q != bcv_pkg::ST_IDLE);
    out_load      = (state_q == bcv_pkg::ST_OUT) && out_free;
    alu_state     = 1'b0;
    alu_req.op    = bcv_pkg::ALU_DIV;
    alu_a         = AW'(smag_q);
    alu_b         = AW'(cnt_q);
    case (state_q)
      bcv_pkg::ST_DIV_MEAN: begin
        alu_state = 1'b1;
      end
      bcv_pkg::ST_MUL_SQ: begin
        alu_state  = 1'b1;
        alu_req.op = bcv_pkg::ALU_MUL;
        alu_b      = AW'(smag_q);
      end
      bcv_pkg::ST_DIV_Q: begin
        alu_state = 1'b1;
        alu_a     = tmp_q;
      end
      bcv_pkg::ST_DIV_VAR: begin
        alu_state = 1'b1;
        alu_a     = tmp_q;
        alu_b     = AW'(nm1);
      end
      default: begin
        alu_state = 1'b0;
      end
    endcase
    alu_req.start = alu_state && !alu_rsp.busy && !alu_rsp.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bcv_pkg::ST_IDLE;
      sum_q       <= '0;
      sqsum_q     <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == bcv_pkg::ST_IDLE && in_acc && full) begin
        ovf_q <= 1'b1;
      end
      if (state_q == bcv_pkg::ST_ACC) begin
        sum_q   <= sum_q + {{CW{x_q[SW-1]}}, x_q};
        sqsum_q <= sqsum_q + QW'(sqr_q);
        cnt_q   <= cnt_q + CW'(1);
      end
      if (out_load) begin
        sum_q   <= '0;
        sqsum_q <= '0;
        cnt_q   <= '0;
        ovf_q   <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      bcv_pkg::ST_IDLE: begin
        if (in_acc) begin
          x_q    <= sample_i;
          mag_q  <= sample_i[SW-1] ? neg_x : sample_i;
          last_q <= last_i;
        end
      end
      bcv_pkg::ST_SQ: begin
        sqr_q <= mag_q * mag_q;
      end
      bcv_pkg::ST_CHK: begin
        sneg_q <= sum_q[SUMW-1];
        smag_q <= sum_q[SUMW-1] ? neg_sum[SUMW-2:0] : sum_q[SUMW-2:0];
        if (cnt_q <= CW'(1)) begin
          var_q  <= '0;
          mean_q <= '0;
          stat_q <= bcv_pkg::STAT_ONE;
        end else begin
          stat_q <= ovf_q ? bcv_pkg::STAT_OVF : bcv_pkg::STAT_OK;
        end
      end
      bcv_pkg::ST_DIV_MEAN: begin
        if (alu_rsp.done) begin
          mean_q <= sneg_q ? (~res_lo + MW'(1)) : res_lo;
        end
      end
      bcv_pkg::ST_MUL_SQ, bcv_pkg::ST_DIV_Q: begin
        if (alu_rsp.done) begin
          tmp_q <= alu_res;
        end
      end
      bcv_pkg::ST_DIFF: begin
        tmp_q <= (sqsum_ext >= tmp_q) ? (sqsum_ext - tmp_q) : '0;
      end
      bcv_pkg::ST_DIV_VAR: begin
        if (alu_rsp.done) begin
          var_q <= (|alu_res[AW-1:VW]) ? {VW{1'b1}} : alu_res[VW-1:0];
        end
      end
      default: begin
        last_q <= last_q;
      end
    endcase
    if (out_load) begin
      var_out_q  <= var_q;
      mean_out_q <= mean_q;
      stat_out_q <= stat_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign corrected_variance_o = var_out_q;
  assign mean_o               = mean_out_q;
  assign status_o             = stat_out_q;

endmodule

@@ sv/bcv_alu.sv @@
// Radix-2 shift-add multiplier and restoring divider sharing one adder.
module bcv_alu (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  bcv_pkg::alu_req_t        req_i,
  input  logic [bcv_pkg::ALU_W-1:0] a_i,
  input  logic [bcv_pkg::ALU_W-1:0] b_i,
  output bcv_pkg::alu_rsp_t        rsp_o,
  output logic [bcv_pkg::ALU_W-1:0] result_o
);

  localparam int unsigned W  = bcv_pkg::ALU_W;
  localparam int unsigned CW = bcv_pkg::ALU_CW;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  bcv_pkg::alu_op_e    op_q, op_d;
  logic [W:0]          x_q, x_d;
  logic [W-1:0]        y_q, y_d;
  logic [W-1:0]        z_q, z_d;
  logic [W:0]          trial;
  logic [W:0]          opa;
  logic [W:0]          opb;
  logic [W+1:0]        sum;
  logic                is_mul;

  assign is_mul = (op_q == bcv_pkg::ALU_MUL);
  assign trial  = {x_q[W-1:0], y_q[W-1]};
  assign opa    = is_mul ? {1'b0, x_q[W-1:0]} : trial;
  assign opb    = is_mul ? {1'b0, z_q} : ~{1'b0, z_q};
  assign sum    = {1'b0, opa} + {1'b0, opb} + {{(W+1){1'b0}}, ~is_mul};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    op_d   = op_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(W);
      op_d   = req_i.op;
      x_d    = '0;
      y_d    = a_i;
      z_d    = b_i;
    end else if (busy_q) begin
      case (op_q)
        bcv_pkg::ALU_MUL: begin
          if (y_q[0]) begin
            x_d = {1'b0, sum[W-1:0]};
          end
          y_d = {1'b0, y_q[W-1:1]};
          z_d = {z_q[W-2:0], 1'b0};
        end
        bcv_pkg::ALU_DIV: begin
          x_d = sum[W+1] ? sum[W:0] : trial;
          y_d = {y_q[W-2:0], sum[W+1]};
        end
        default: begin
          x_d = x_q;
        end
      endcase
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    x_q  <= x_d;
    y_q  <= y_d;
    z_q  <= z_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign result_o   = is_mul ? x_q[W-1:0] : y_q;

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the Bessel-corrected variance block.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SET_CAPACITY = bcv_pkg::MAX_COUNT_DEF;
  localparam int unsigned RANDOM_ITEMS = 1120;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 300;

  typedef struct packed {
    logic [bcv_pkg::VAR_W-1:0]  variance;
    logic [bcv_pkg::MEAN_W-1:0] mean;
    bcv_pkg::status_e           status;
  } moments_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SCATTER,
    STALL_RUNS
  } stall_mode_e;

  typedef enum logic [1:0] {
    SHAPE_FULL,
    SHAPE_NEAR,
    SHAPE_EDGE,
    SHAPE_FLAT
  } sample_shape_e;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid_i  = 1'b0;
  logic                         in_stall_o;
  logic [15:0]                  sample_i    = '0;
  logic                         last_i      = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [bcv_pkg::VAR_W-1:0]    corrected_variance_o;
  logic [bcv_pkg::MEAN_W-1:0]   mean_o;
  logic [bcv_pkg::STAT_W-1:0]   status_o;

  moments_t    pending_results[$];
  moments_t    want;
  logic [63:0] acc_sum     = '0;
  logic [63:0] acc_sq_sum  = '0;
  int unsigned acc_count   = 0;
  logic        acc_full    = 1'b0;

  int unsigned items_sent   = 0;
  int unsigned sets_sent    = 0;
  int unsigned results_seen = 0;
  int unsigned errors       = 0;
  int unsigned cycle_count  = 0;
  int unsigned burst_left   = 0;
  stall_mode_e stall_mode   = STALL_NONE;
  int unsigned stall_left   = 0;

  bessel_corrected_variance u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .sample_i            (sample_i),
    .last_i              (last_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .corrected_variance_o(corrected_variance_o),
    .mean_o              (mean_o),
    .status_o            (status_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(2, 0));
      stall_left = $urandom_range(400, 20);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE: out_stall_i <= 1'b0;
      STALL_SCATTER: out_stall_i <= ($urandom_range(9, 0) < 3);
      default: begin
        if ($urandom_range(7, 0) == 0) out_stall_i <= ~out_stall_i;
      end
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected: variance %h mean %h status %0d",
                 $time, corrected_variance_o, mean_o, status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (corrected_variance_o !== want.variance) begin
          $display("%0t: variance expected %h actual %h", $time, want.variance,
                   corrected_variance_o);
          errors++;
        end
        if (mean_o !== want.mean) begin
          $display("%0t: mean expected %0d actual %0d", $time, $signed(want.mean),
                   $signed(mean_o));
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
      end
    end
  end

  // Adds an item, or flags overflow if full; on a set's last, queues the result.
  task automatic update_moments(input logic [15:0] smp, input logic lst);
    logic [63:0] x;
    logic [63:0] mag;
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] diff;
    logic [63:0] quot;
    logic        neg;
    moments_t    r;
    x = {{48{smp[15]}}, smp};
    if (acc_count >= SET_CAPACITY) begin
      acc_full = 1'b1;
    end else begin
      mag = x[63] ? -x : x;
      acc_sum = acc_sum + x;
      acc_sq_sum = acc_sq_sum + mag * mag;
      acc_count++;
    end
    if (lst) begin
      n = 64'(acc_count);
      if (n <= 1) begin
        r = '{variance: '0, mean: '0, status: bcv_pkg::STAT_ONE};
      end else begin
        neg = acc_sum[63];
        mag = neg ? -acc_sum : acc_sum;
        quot = mag / n;
        if (neg) quot = -quot;
        r.mean = quot[bcv_pkg::MEAN_W-1:0];
        q = (mag * mag) / n;
        diff = (acc_sq_sum >= q) ? acc_sq_sum - q : '0;
        quot = diff / (n - 1);
        r.variance = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[bcv_pkg::VAR_W-1:0];
        r.status = acc_full ? bcv_pkg::STAT_OVF : bcv_pkg::STAT_OK;
      end
      pending_results = {pending_results, r};
      sets_sent++;
      acc_sum = '0;
      acc_sq_sum = '0;
      acc_count = 0;
      acc_full = 1'b0;
    end
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic lst);
    in_valid_i <= 1'b1;
    sample_i <= smp;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    update_moments(smp, lst);
    items_sent++;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(120, 40)
                                               : $urandom_range(16, 0);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    burst_left = 0;
  endtask

  function automatic logic [15:0] pick_sample(input sample_shape_e shape,
                                              input logic [15:0] base);
    logic [15:0] offs;
    offs = 16'($urandom_range(128, 0));
    case (shape)
      SHAPE_NEAR: pick_sample = base + offs - 16'd64;
      SHAPE_EDGE: begin
        offs = 16'($urandom_range(3, 0));
        pick_sample = $urandom_range(1, 0) ? 16'h7FFF - offs : 16'h8000 + offs;
      end
      SHAPE_FLAT: pick_sample = base;
      default: pick_sample = 16'($urandom);
    endcase
  endfunction

  task automatic test_extremes();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0000, 1'b1);
    drain_results();
  endtask

  task automatic test_single_sample();
    send_sample(16'h8000, 1'b1);
    send_sample(16'h7FFF, 1'b1);
    drain_results();
  endtask

  task automatic test_truncation();
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFE, 1'b1);
    send_sample(16'hFFFD, 1'b0);
    send_sample(16'hFFFC, 1'b0);
    send_sample(16'hFFFC, 1'b1);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h0002, 1'b1);
    send_sample(16'd100, 1'b0);
    send_sample(-16'sd100, 1'b1);
    drain_results();
  endtask

  task automatic test_random_sets();
    int unsigned   start;
    int unsigned   set_len;
    int unsigned   pick;
    sample_shape_e shape;
    logic [15:0]   base;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      pick = $urandom_range(99, 0);
      if (pick < 8) set_len = 1;
      else if (pick < 85) set_len = $urandom_range(12, 2);
      else if (pick < 97) set_len = $urandom_range(40, 13);
      else set_len = $urandom_range(200, 41);
      shape = sample_shape_e'($urandom_range(3, 0));
      base = 16'($urandom);
      for (int unsigned i = 1; i <= set_len; i++) begin
        send_sample(pick_sample(shape, base), i == set_len);
      end
      if ($urandom_range(7, 0) == 0) drain_results();
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_single_sample();
    test_truncation();
    test_random_sets();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Sent %0d samples in %0d sets and checked %0d results in %0d cycles,",
             items_sent, sets_sent, results_seen, cycle_count);
    $display("with extremes, single-sample sets, truncation and random sets under stalls.");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ bessel_corrected_variance.f @@
sv/bcv_pkg.sv
sv/bcv_alu.sv
sv/bessel_corrected_variance.sv
bench/testbench.sv
